/* rtl/tcls_pkg.sv */
package tcls_pkg;

	// default sizes
	localparam int DEF_QUEUE_DEPTH = 8;
	localparam int DEF_LINE_LIMIT  = 64;
	localparam int DEF_SOURCES     = 2;

	// operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// configuration register indexes
	localparam logic REG_TRAVEL   = 1'b0;
	localparam logic REG_MIN_LEAD = 1'b1;

	// event codes
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_SYNC    = 3'd1;
	localparam logic [2:0] EV_QUEUED  = 3'd2;
	localparam logic [2:0] EV_DROPPED = 3'd3;
	localparam logic [2:0] EV_NO_SYNC = 3'd4;
	localparam logic [2:0] EV_DISCARD = 3'd5;

	// keyword kind
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SYNC  = 2'd1;
	localparam logic [1:0] KIND_STAMP = 2'd2;

	// number phase
	localparam logic [1:0] PH_BLANK = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [3:0] SYNC_LEN  = 4'd8;
	localparam logic [3:0] STAMP_LEN = 4'd13;

	localparam logic [7:0] CH_NEWLINE = 8'd10;

	// result of one byte as seen by the line parser
	typedef struct packed {
		logic        sync_hit;   // complete sync line ended
		logic        stamp_hit;  // complete timestamp line ended
		logic        too_long;   // byte dropped, line discarded
		logic [31:0] number;     // parsed value, two's complement
	} parse_res_t;

	// sync command keyword
	function automatic logic [7:0] sync_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0:    c = "S";
			4'd1:    c = "Y";
			4'd2:    c = "N";
			4'd3:    c = "C";
			4'd4:    c = "_";
			4'd5:    c = "M";
			4'd6:    c = "S";
			4'd7:    c = "=";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// detection stamp command keyword
	function automatic logic [7:0] stamp_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0:    c = "T";
			4'd1:    c = "I";
			4'd2:    c = "M";
			4'd3:    c = "E";
			4'd4:    c = "S";
			4'd5:    c = "T";
			4'd6:    c = "A";
			4'd7:    c = "M";
			4'd8:    c = "P";
			4'd9:    c = "_";
			4'd10:   c = "M";
			4'd11:   c = "S";
			4'd12:   c = "=";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* rtl/tcls_ram.sv */
module tcls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/tcls_queue.sv */
module tcls_queue #(
	parameter int QUEUE_DEPTH = 8,
	localparam int PTR_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [31:0]      push_data,
	input  logic             pop,
	output logic [31:0]      head,
	output logic             full,
	output logic             empty,
	output logic [CNT_W-1:0] count_next
);

	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_next;
	logic [CNT_W-1:0] cnt_q;
	logic             byp_q;
	logic [31:0]      byp_data_q;
	logic [31:0]      ram_rdata;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full        = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty       = (cnt_q == '0);
	assign rd_ptr_next = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
	assign count_next  = cnt_q + CNT_W'(push) - CNT_W'(pop);

	// RAM always reads the head that applies after this edge
	tcls_ram #(
		.WIDTH (32),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push),
		.waddr (wr_ptr_q),
		.wdata (push_data),
		.raddr (rd_ptr_next),
		.rdata (ram_rdata)
	);

	// write into the slot being read: forward the new word for one cycle
	assign head = byp_q ? byp_data_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
			byp_q    <= 1'b0;
		end else begin
			rd_ptr_q <= rd_ptr_next;
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			cnt_q <= count_next;
			byp_q <= push && (wr_ptr_q == rd_ptr_next);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= push_data;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

/* rtl/tcls_parser.sv */
module tcls_parser #(
	parameter int SOURCES    = 2,
	parameter int LINE_LIMIT = 64,
	localparam int SRC_W = (SOURCES > 1) ? $clog2(SOURCES) : 1,
	localparam int LEN_W = $clog2(LINE_LIMIT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [SRC_W-1:0]     src,
	input  logic [7:0]           rx_byte,
	output tcls_pkg::parse_res_t res
);

	import tcls_pkg::*;

	logic [LEN_W-1:0] len_q  [SOURCES];
	logic [3:0]       mp_q   [SOURCES];
	logic [1:0]       kind_q [SOURCES];
	logic [1:0]       ph_q   [SOURCES];
	logic             neg_q  [SOURCES];
	logic [31:0]      val_q  [SOURCES];

	logic [LEN_W-1:0] cur_len, nxt_len;
	logic [3:0]       cur_mp, nxt_mp, klen;
	logic [1:0]       cur_kind, nxt_kind, cur_ph, nxt_ph;
	logic             cur_neg, nxt_neg;
	logic [31:0]      cur_val, nxt_val, sat_val;
	logic [35:0]      acc;
	logic [7:0]       kw_c;
	logic             is_nl, is_ws, is_digit;

	assign cur_len  = len_q[src];
	assign cur_mp   = mp_q[src];
	assign cur_kind = kind_q[src];
	assign cur_ph   = ph_q[src];
	assign cur_neg  = neg_q[src];
	assign cur_val  = val_q[src];

	assign is_nl    = (rx_byte == CH_NEWLINE);
	assign is_ws    = (rx_byte == " ") || (rx_byte >= 8'd9 && rx_byte <= 8'd13);
	assign is_digit = (rx_byte >= "0") && (rx_byte <= "9");

	// value*10 + digit, saturated at 2^31
	assign acc     = ({4'b0, cur_val} << 3) + ({4'b0, cur_val} << 1)
	               + {32'b0, rx_byte[3:0]};
	assign sat_val = (acc > 36'h080000000) ? 32'h80000000 : acc[31:0];

	assign klen = (cur_kind == KIND_SYNC) ? SYNC_LEN : STAMP_LEN;
	assign kw_c = (cur_kind == KIND_SYNC) ? sync_char(cur_mp) : stamp_char(cur_mp);

	always_comb begin
		res.sync_hit  = is_nl && (cur_len != '0) && (cur_kind == KIND_SYNC)
		                && (cur_mp == SYNC_LEN);
		res.stamp_hit = is_nl && (cur_len != '0) && (cur_kind == KIND_STAMP)
		                && (cur_mp == STAMP_LEN);
		res.too_long  = !is_nl && (cur_len >= LEN_W'(LINE_LIMIT - 1));
		if (cur_neg) begin
			res.number = 32'd0 - cur_val;
		end else begin
			res.number = cur_val[31] ? 32'h7FFFFFFF : cur_val;
		end
	end

	always_comb begin
		nxt_len  = cur_len;
		nxt_mp   = cur_mp;
		nxt_kind = cur_kind;
		nxt_ph   = cur_ph;
		nxt_neg  = cur_neg;
		nxt_val  = cur_val;
		if (is_nl || res.too_long) begin
			nxt_len  = '0;
			nxt_mp   = '0;
			nxt_kind = KIND_NONE;
			nxt_ph   = PH_BLANK;
			nxt_neg  = 1'b0;
			nxt_val  = '0;
		end else begin
			nxt_len = cur_len + 1'b1;
			if (cur_len == '0) begin
				if (rx_byte == "S") begin
					nxt_kind = KIND_SYNC;
					nxt_mp   = 4'd1;
				end else if (rx_byte == "T") begin
					nxt_kind = KIND_STAMP;
					nxt_mp   = 4'd1;
				end else begin
					nxt_kind = KIND_NONE;
				end
			end else if (cur_kind != KIND_NONE) begin
				if (cur_mp < klen) begin
					if (rx_byte == kw_c) begin
						nxt_mp = cur_mp + 4'd1;
					end else begin
						nxt_kind = KIND_NONE;
					end
				end else if (cur_ph == PH_BLANK && is_ws) begin
					nxt_ph = cur_ph;
				end else if (cur_ph == PH_BLANK && rx_byte == "+") begin
					nxt_ph = PH_SIGN;
				end else if (cur_ph == PH_BLANK && rx_byte == "-") begin
					nxt_neg = 1'b1;
					nxt_ph  = PH_SIGN;
				end else if (cur_ph == PH_DONE) begin
					nxt_ph = cur_ph;
				end else if (!is_digit) begin
					nxt_ph = PH_DONE;
				end else begin
					nxt_val = sat_val;
					nxt_ph  = PH_DIGIT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCES; i++) begin
				len_q[i]  <= '0;
				mp_q[i]   <= '0;
				kind_q[i] <= KIND_NONE;
				ph_q[i]   <= PH_BLANK;
				neg_q[i]  <= 1'b0;
				val_q[i]  <= '0;
			end
		end else if (en) begin
			len_q[src]  <= nxt_len;
			mp_q[src]   <= nxt_mp;
			kind_q[src] <= nxt_kind;
			ph_q[src]   <= nxt_ph;
			neg_q[src]  <= nxt_neg;
			val_q[src]  <= nxt_val;
		end
	end

endmodule

/* rtl/timestamp_command_line_scheduler_top.sv */
// channel   dir  handshake             word
// --------  ---  --------------------  ----------------------------------------------
// input     in   in_valid / in_ready   op, source, rx_byte, now_ms
// result    out  out_valid / out_ready event_res, late, pop_valid,
//                                      popped_arrival_ms, pending
// config    in   cfg_we                cfg_index, cfg_data (write only)
//
// One word per cycle sustained while out_ready is high; a word accepted into the
// input register moves on to the result register once the result slot is free
// or being read out (input register, one pass of parse/queue logic, result register).
// The head-of-queue read comes from a registered RAM that is addressed with the
// next read pointer, with a forward path for a write into the slot being read.
// Reset clears line state, sync, offset, queue pointers, valid flags and config registers.
// Queue contents are not cleared. A stalled result holds the input register
// and accepts no more words until out_ready frees the result slot.
module timestamp_command_line_scheduler_top #(
	parameter int QUEUE_DEPTH = tcls_pkg::DEF_QUEUE_DEPTH,
	parameter int LINE_LIMIT  = tcls_pkg::DEF_LINE_LIMIT,
	parameter int SOURCES     = tcls_pkg::DEF_SOURCES
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic        source,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_ms,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic        late,
	output logic        pop_valid,
	output logic [31:0] popped_arrival_ms,
	output logic [3:0]  pending
);

	import tcls_pkg::*;

	localparam int SRC_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// configuration registers
	logic [19:0] travel_q;
	logic [15:0] min_lead_q;

	// input stage
	logic        valid_s1;
	logic        op_s1;
	logic        src_s1;
	logic [7:0]  byte_s1;
	logic [31:0] now_s1;

	// result stage
	logic        valid_s2;
	logic [2:0]  ev_s2;
	logic        late_s2;
	logic        pv_s2;
	logic [31:0] popped_s2;
	logic [3:0]  pending_s2;

	// clock sync
	logic        sync_seen_q;
	logic [31:0] offset_q;

	logic             advance;
	logic [SRC_W-1:0] src_idx;
	logic             is_byte;
	parse_res_t       pr;
	logic             q_full, q_empty, q_push, q_pop;
	logic [CNT_W-1:0] q_count_next;
	logic [CNT_W+3:0] cnt_ext;
	logic [31:0]      q_head;
	logic [31:0]      arrival, lead;
	logic             is_late;
	logic [2:0]       ev;
	logic             stamp_ok;

	// the word in the input register moves on whenever the result slot is free or being read out
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign src_idx  = SRC_W'(src_s1);
	assign is_byte  = (op_s1 == OP_BYTE) && (int'(src_idx) < SOURCES);

	tcls_parser #(
		.SOURCES    (SOURCES),
		.LINE_LIMIT (LINE_LIMIT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance && is_byte),
		.src     (src_idx),
		.rx_byte (byte_s1),
		.res     (pr)
	);

	// predicted arrival and lead time, all mod 2^32
	assign arrival  = pr.number + offset_q + {12'b0, travel_q};
	assign lead     = arrival - now_s1;
	assign is_late  = lead[31] || (lead < {16'b0, min_lead_q});
	assign stamp_ok = is_byte && pr.stamp_hit && sync_seen_q;

	assign q_push = advance && stamp_ok && !q_full;
	assign q_pop  = advance && (op_s1 == OP_POP) && !q_empty;

	tcls_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (arrival),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty),
		.count_next (q_count_next)
	);

	// occupancy reported in four bits
	assign cnt_ext = {4'b0, q_count_next};

	always_comb begin
		ev = EV_NONE;
		if (is_byte) begin
			if (pr.sync_hit) begin
				ev = EV_SYNC;
			end else if (pr.stamp_hit) begin
				if (!sync_seen_q) begin
					ev = EV_NO_SYNC;
				end else if (q_full) begin
					ev = EV_DROPPED;
				end else begin
					ev = EV_QUEUED;
				end
			end else if (pr.too_long) begin
				ev = EV_DISCARD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q   <= '0;
			min_lead_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRAVEL:   travel_q   <= cfg_data;
				REG_MIN_LEAD: min_lead_q <= cfg_data[15:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			sync_seen_q <= 1'b0;
			offset_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (advance && is_byte && pr.sync_hit) begin
				sync_seen_q <= 1'b1;
				offset_q    <= now_s1 - pr.number;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			src_s1  <= source;
			byte_s1 <= rx_byte;
			now_s1  <= now_ms;
		end
		if (advance) begin
			ev_s2      <= ev;
			late_s2    <= stamp_ok && is_late;
			pv_s2      <= q_pop;
			popped_s2  <= q_pop ? q_head : 32'd0;
			pending_s2 <= cnt_ext[3:0];
		end
	end

	assign out_valid         = valid_s2;
	assign event_res         = ev_s2;
	assign late              = late_s2;
	assign pop_valid         = pv_s2;
	assign popped_arrival_ms = popped_s2;
	assign pending           = pending_s2;

`ifndef SYNTHESIS
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with free result slot");
`endif

endmodule
